// ===== design/tpt_svf_pkg.sv =====
// Shared types, codes and helpers for the trapezoidal state variable filter.
`timescale 1ns / 1ps

package tpt_svf_pkg;

    localparam int STATE_W = 32;
    localparam int OP_W    = 33;
    localparam int PROD_W  = 2 * OP_W;
    localparam int EXT_W   = 40;
    localparam int CFG_IDX_W = 3;

    typedef logic signed [STATE_W-1:0] state_word_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic signed [EXT_W-1:0]   ext_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_A1      = 3'd0,
        CFG_A2      = 3'd1,
        CFG_A3      = 3'd2,
        CFG_DAMPING = 3'd3,
        CFG_GAIN    = 3'd4,
        CFG_MODE    = 3'd5
    } cfg_idx_t;

    localparam logic [1:0] MODE_HIGHPASS = 2'd1;
    localparam logic [1:0] MODE_BANDPASS = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL1,
        S_MUL2,
        S_MUL3,
        S_MUL4,
        S_MUL5,
        S_FILT,
        S_GAIN,
        S_ROUND
    } svf_state_t;

    typedef struct packed {
        logic                   en;
        logic signed [OP_W-1:0] op_a;
        logic signed [OP_W-1:0] op_b;
    } mul_req_t;

    function automatic state_word_t sat32(input ext_t v);
        ext_t hi;
        ext_t lo;
        hi = EXT_W'(64'sd2147483647);
        lo = -hi - EXT_W'(64'sd1);
        if (v > hi) begin
            sat32 = STATE_W'(hi);
        end else if (v < lo) begin
            sat32 = STATE_W'(lo);
        end else begin
            sat32 = STATE_W'(v);
        end
    endfunction

endpackage

// ===== design/tpt_state_variable_filter_top.sv =====
// Top level of the trapezoidal state variable filter with per-channel integrators.
// A word passes from idle through five multiply states, filter, gain and rounding, and the
// next word is accepted once the sequencer is back in idle; an out-of-range channel skips
// to rounding. Pace is set by the six dependent products through the one shared multiplier.
// The output register lets the next word enter while a result waits to be taken.
// Reset is synchronous and active low; it clears the integrators and loads register defaults.
`timescale 1ns / 1ps

module tpt_state_variable_filter_top #(
    parameter int CHANNELS    = 2,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // s_tdata fields from bit 0: sample_in
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]     s_tdata,
    // s_tuser fields from bit 0: channel_index
    input  logic                                 s_tuser,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // m_tdata fields from bit 0: sample_out
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]     m_tdata,
    // m_tuser fields from bit 0: channel_out
    output logic                                 m_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [tpt_svf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [31:0]                          cfg_data
);
    import tpt_svf_pkg::*;

    localparam int DATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int Y_W    = PROD_W - 24;
    localparam prod_t HALF30 = PROD_W'(64'sd1 <<< 29);
    localparam prod_t HALF27 = PROD_W'(64'sd1 <<< 26);
    localparam prod_t HALF24 = PROD_W'(64'sd1 <<< 23);
    localparam logic signed [Y_W-1:0] Y_MAX = Y_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [Y_W-1:0] Y_MIN = -Y_MAX - Y_W'(64'sd1);

    svf_state_t state_reg, state_next;

    logic [30:0] a1_reg, a2_reg, a3_reg, damp_reg;
    logic [31:0] gain_reg;
    logic [1:0]  mode_reg;

    state_word_t integ1_reg [CHANNELS];
    state_word_t integ2_reg [CHANNELS];

    logic [CH_W-1:0] ch_idx_reg;
    logic            ch_reg;
    logic            skip_reg;
    state_word_t     x_reg, ic1_reg, ic2_reg, v3_reg, band_reg, low_reg, filt_reg;
    prod_t           hold_reg;

    logic                   m_tvalid_reg;
    logic                   m_tuser_reg;
    logic [SAMPLE_BITS-1:0] m_sample_reg;

    mul_req_t mreq;
    prod_t    prod;

    logic                          in_accept;
    logic                          in_range;
    logic                          slot_free;
    logic signed [SAMPLE_BITS-1:0] s_sample;
    prod_t                         sum_w;
    prod_t                         rnd30;
    prod_t                         rnd27;
    prod_t                         rnd24;
    ext_t                          high_w;
    state_word_t                   v3_w, band_w, low_w, filt_w, i1_new, i2_new;
    logic signed [Y_W-1:0]         y_w;
    logic [SAMPLE_BITS-1:0]        y_sat;

    tpt_svf_mul u_mul (
        .aclk (aclk),
        .req  (mreq),
        .prod (prod)
    );

    assign in_accept = s_tvalid && s_tready;
    assign in_range  = (32'(s_tuser) < CHANNELS);
    assign slot_free = !m_tvalid_reg || m_tready;
    assign s_sample  = s_tdata[SAMPLE_BITS-1:0];
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a1_reg   <= 31'd1073741824;
            a2_reg   <= 31'd0;
            a3_reg   <= 31'd0;
            damp_reg <= 31'd134217728;
            gain_reg <= 32'd16777216;
            mode_reg <= 2'd0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_A1:      a1_reg   <= cfg_data[30:0];
                CFG_A2:      a2_reg   <= cfg_data[30:0];
                CFG_A3:      a3_reg   <= cfg_data[30:0];
                CFG_DAMPING: damp_reg <= cfg_data[30:0];
                CFG_GAIN:    gain_reg <= cfg_data;
                CFG_MODE:    mode_reg <= cfg_data[1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next = in_range ? S_MUL1 : S_ROUND;
                end
            end
            S_MUL1:  state_next = S_MUL2;
            S_MUL2:  state_next = S_MUL3;
            S_MUL3:  state_next = S_MUL4;
            S_MUL4:  state_next = S_MUL5;
            S_MUL5:  state_next = S_FILT;
            S_FILT:  state_next = S_GAIN;
            S_GAIN:  state_next = S_ROUND;
            S_ROUND: begin
                if (slot_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        s_tready  = 1'b0;
        mreq.en   = 1'b0;
        mreq.op_a = '0;
        mreq.op_b = '0;
        case (state_reg)
            S_IDLE: s_tready = 1'b1;
            S_MUL1: begin
                mreq.en   = 1'b1;
                mreq.op_a = OP_W'(a1_reg);
                mreq.op_b = OP_W'(ic1_reg);
            end
            S_MUL2: begin
                mreq.en   = 1'b1;
                mreq.op_a = OP_W'(a2_reg);
                mreq.op_b = OP_W'(v3_reg);
            end
            S_MUL3: begin
                mreq.en   = 1'b1;
                mreq.op_a = OP_W'(a2_reg);
                mreq.op_b = OP_W'(ic1_reg);
            end
            S_MUL4: begin
                mreq.en   = 1'b1;
                mreq.op_a = OP_W'(a3_reg);
                mreq.op_b = OP_W'(v3_reg);
            end
            S_MUL5: begin
                mreq.en   = 1'b1;
                mreq.op_a = OP_W'(damp_reg);
                mreq.op_b = OP_W'(band_reg);
            end
            S_GAIN: begin
                mreq.en   = 1'b1;
                mreq.op_a = OP_W'(gain_reg);
                mreq.op_b = OP_W'(filt_reg);
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        v3_w   = sat32(EXT_W'(x_reg) - EXT_W'(ic2_reg));
        sum_w  = hold_reg + prod;
        rnd30  = (sum_w + HALF30) >>> 30;
        band_w = sat32(EXT_W'(rnd30));
        low_w  = sat32(EXT_W'(ic2_reg) + EXT_W'(rnd30));
        rnd27  = (prod + HALF27) >>> 27;
        high_w = EXT_W'(x_reg) - EXT_W'(rnd27) - EXT_W'(low_reg);
        case (mode_reg)
            MODE_HIGHPASS: filt_w = sat32(high_w);
            MODE_BANDPASS: filt_w = band_reg;
            default:       filt_w = low_reg;
        endcase
        i1_new = sat32((EXT_W'(band_reg) <<< 1) - EXT_W'(ic1_reg));
        i2_new = sat32((EXT_W'(low_reg) <<< 1) - EXT_W'(ic2_reg));
        rnd24  = (prod + HALF24) >>> 24;
        y_w    = Y_W'(rnd24);
        if (skip_reg) begin
            y_sat = '0;
        end else if (y_w > Y_MAX) begin
            y_sat = SAMPLE_BITS'(Y_MAX);
        end else if (y_w < Y_MIN) begin
            y_sat = SAMPLE_BITS'(Y_MIN);
        end else begin
            y_sat = SAMPLE_BITS'(y_w);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
            for (int i = 0; i < CHANNELS; i++) begin
                integ1_reg[i] <= '0;
                integ2_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (state_reg == S_ROUND && slot_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (state_reg == S_FILT) begin
                integ1_reg[ch_idx_reg] <= i1_new;
                integ2_reg[ch_idx_reg] <= i2_new;
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            S_IDLE: begin
                if (in_accept) begin
                    ch_reg     <= s_tuser;
                    ch_idx_reg <= CH_W'(s_tuser);
                    skip_reg   <= !in_range;
                    x_reg      <= STATE_W'(s_sample);
                    if (in_range) begin
                        ic1_reg <= integ1_reg[CH_W'(s_tuser)];
                        ic2_reg <= integ2_reg[CH_W'(s_tuser)];
                    end
                end
            end
            S_MUL1: v3_reg <= v3_w;
            S_MUL2: hold_reg <= prod;
            S_MUL3: band_reg <= band_w;
            S_MUL4: hold_reg <= prod;
            S_MUL5: low_reg <= low_w;
            S_FILT: filt_reg <= filt_w;
            S_ROUND: begin
                if (slot_free) begin
                    m_sample_reg <= y_sat;
                    m_tuser_reg  <= ch_reg;
                end
            end
            default: begin
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tdata  = DATA_W'(m_sample_reg);

endmodule

// ===== design/tpt_svf_mul.sv =====
// Shared signed multiplier with a registered product.
`timescale 1ns / 1ps

module tpt_svf_mul (
    input  logic                   aclk,
    input  tpt_svf_pkg::mul_req_t  req,
    output tpt_svf_pkg::prod_t     prod
);
    import tpt_svf_pkg::*;

    prod_t prod_reg;

    always_ff @(posedge aclk) begin
        if (req.en) begin
            prod_reg <= req.op_a * req.op_b;
        end
    end

    assign prod = prod_reg;

endmodule

// ===== design/tpt_svf_chk.sv =====
// Port-level checks for the state variable filter and their binding to the top level.
`timescale 1ns / 1ps

module tpt_svf_chk #(
    parameter int SAMPLE_BITS = 24
) (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [((SAMPLE_BITS+7)/8)*8-1:0] m_tdata,
    input logic                             m_tuser
);

    // A stalled result word must hold.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // The sequencer is busy right after it takes a word.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready right after an accepted word");

    // A new result only appears at the end of the work on a word.
    a_result_from_work: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result appeared while the sequencer was idle");

    // Reset empties the output register.
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind tpt_state_variable_filter_top tpt_svf_chk #(.SAMPLE_BITS(SAMPLE_BITS)) u_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
